[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a property, off while reset is asserted
`define DBC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// concurrent check that a condition never holds
`define DBC_ASSERT_NEVER(name, clk, rst_n, cond) \
  `DBC_ASSERT(name, clk, rst_n, !(cond))

`endif

[hw/rtl/dbc_pkg.sv]
package dbc_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_MAX_DIMS   = 4;
  localparam int DEF_COORD_BITS = 16;

  localparam int IN_FIELD_W  = 16;
  localparam int IN_FIELDS   = 4;
  localparam int IN_DATA_W   = IN_FIELD_W * IN_FIELDS;
  localparam int OUT_DATA_W  = 32;

  localparam int EPS_W      = 16;
  localparam int MINPTS_W   = 7;
  localparam int DIMS_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LBL_W      = 7;
  localparam int TOT_W      = 7;
  localparam int PIDX_W     = 6;

  localparam logic [EPS_W-1:0]    EPS_RST    = 16'd256;
  localparam logic [MINPTS_W-1:0] MINPTS_RST = 7'd4;
  localparam logic [DIMS_W-1:0]   DIMS_RST   = 3'd2;
  localparam logic [LBL_W-1:0]    LBL_NOISE  = 7'h7F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EPS    = 2'd0,
    CFG_MINPTS = 2'd1,
    CFG_ADAPT  = 2'd2,
    CFG_DIMS   = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_LOAD,
    S_START,
    S_LONE,
    S_BASE,
    S_BASEW,
    S_RROW,
    S_RCAND,
    S_RCW,
    S_RCNT,
    S_RCHK,
    S_RWR,
    S_OUTER,
    S_NEXT,
    S_NBR,
    S_DEC,
    S_PUSH,
    S_POP,
    S_POPW,
    S_OUT_RD,
    S_OUT_SHOW
  } state_e;

endpackage

[hw/rtl/dbc_lane.sv]
module dbc_lane #(
  parameter int COORD_BITS = dbc_pkg::DEF_COORD_BITS
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [COORD_BITS-1:0]     a_i,
  input  logic [COORD_BITS-1:0]     b_i,
  output logic [2*COORD_BITS-1:0]   sq_o
);

  logic signed [COORD_BITS:0]     diff;
  logic        [COORD_BITS-1:0]   mag;
  logic        [2*COORD_BITS-1:0] sq_d, sq_q;

  always_comb begin
    diff = $signed({a_i[COORD_BITS-1], a_i}) - $signed({b_i[COORD_BITS-1], b_i});
    mag  = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
    sq_d = en_i ? mag * mag : '0;
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

[hw/rtl/dbc_merge.sv]
module dbc_merge #(
  parameter int MAX_DIMS   = dbc_pkg::DEF_MAX_DIMS,
  parameter int COORD_BITS = dbc_pkg::DEF_COORD_BITS
) (
  input  logic                             clk_i,
  input  logic [MAX_DIMS*2*COORD_BITS-1:0] sq_i,
  output logic [2*COORD_BITS+1:0]          sum_o
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 2;

  logic [SUM_W-1:0] sum_d, sum_q;

  always_comb begin
    sum_d = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      sum_d = sum_d + SUM_W'(sq_i[d*SQ_W +: SQ_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

[hw/rtl/dbscan_cluster_labeler.sv]
// Load: one point per cycle while s_axis_tready_o is high.
// Clustering: each distance walk streams one pair per cycle through a 3-stage
// read/lane/merge pipeline; adaptive radius adds a k-th selection per point.
// Output: each label is read in S_OUT_RD, then held in S_OUT_SHOW until taken.
// Reset (async, rst_ni low) clears counters, flags and state; registers return
// to eps 256, min_points 4, fixed radius, 2 dims.
module dbscan_cluster_labeler #(
  parameter int MAX_POINTS = dbc_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIMS   = dbc_pkg::DEF_MAX_DIMS,
  parameter int COORD_BITS = dbc_pkg::DEF_COORD_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dbc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dbc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // coord_0, coord_1, coord_2, coord_3
  input  logic [dbc_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // point_index, cluster_label, cluster_total, noise_total, overflowed, zero pad
  output logic [dbc_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 2;
  localparam int PT_W   = MAX_DIMS * COORD_BITS;
  localparam int EPS2_W = 2 * dbc_pkg::EPS_W;
  localparam int RAD_W  = (SUM_W + 4 > EPS2_W + 2) ? SUM_W + 4 : EPS2_W + 2;

  dbc_pkg::state_e state_q, state_d;

  // configuration
  logic [dbc_pkg::EPS_W-1:0]    eps_q;
  logic [dbc_pkg::MINPTS_W-1:0] minpts_q;
  logic                         adapt_q;
  logic [dbc_pkg::DIMS_W-1:0]   dims_q;

  // control
  logic [CNT_W-1:0]      cnt_q, i_q, p_q, m_q, c_q, sw_j_q, head_q, tail_q;
  logic [CNT_W-1:0]      out_i_q, lab_cnt_q, cluster_q, nb_cnt_q, cnt_lt_q, cnt_le_q;
  logic                  ovf_q, phase_rad_q, from_outer_q, sw_iss_q;
  logic                  v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]      j1_q, j2_q, j3_q;
  logic [MAX_POINTS-1:0] labeled_q, visited_q, queued_q, nb_mask_q;

  // payload
  logic [EPS2_W-1:0] eps2_q;
  logic [PT_W-1:0]   base_q, pt_rd_q;
  logic [RAD_W-1:0]  radius_q, rad_rd_q, r9_q;
  logic [SUM_W-1:0]  dc_q, drow_rd_q;
  logic [CNT_W-1:0]  lbl_rd_q;
  logic [IDX_W-1:0]  q_rd_q;

  // memories
  logic [PT_W-1:0]   pt_mem   [MAX_POINTS];
  logic [RAD_W-1:0]  rad_mem  [MAX_POINTS];
  logic [SUM_W-1:0]  drow_mem [MAX_POINTS];
  logic [CNT_W-1:0]  lbl_mem  [MAX_POINTS];
  logic [IDX_W-1:0]  q_mem    [MAX_POINTS];

  logic                       in_fire, out_fire, sw_last, pt_drained, dr_drained;
  logic                       core, found, push_ok, n_last, out_last;
  logic [IDX_W-1:0]           pt_addr, drow_addr, cur;
  logic [PT_W-1:0]            in_pt;
  logic [dbc_pkg::DIMS_W-1:0] dims_eff;
  logic [dbc_pkg::EPS_W-1:0]  eps_eff;
  logic [dbc_pkg::MINPTS_W-1:0] mpe;
  logic [7:0]                 idx_sel, mpe_m1, m_m1;
  logic [MAX_DIMS*SQ_W-1:0]   lane_sq;
  logic [SUM_W-1:0]           dist3;
  logic                       nb3;
  logic [RAD_W-1:0]           eps2_ext, rad_new;
  logic                       pt_sweep, sweep_st;
  logic [dbc_pkg::LBL_W-1:0]  lbl_out;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    dims_eff = dims_q;
    if (dims_q == '0) begin
      dims_eff = dbc_pkg::DIMS_W'(1);
    end else if (dims_q > dbc_pkg::DIMS_W'(MAX_DIMS)) begin
      dims_eff = dbc_pkg::DIMS_W'(MAX_DIMS);
    end
    eps_eff = (eps_q == '0) ? dbc_pkg::EPS_W'(1) : eps_q;
    mpe     = (minpts_q < dbc_pkg::MINPTS_W'(2)) ? dbc_pkg::MINPTS_W'(2) : minpts_q;
    mpe_m1  = 8'(mpe) - 8'd1;
    m_m1    = 8'(m_q) - 8'd1;
    idx_sel = (mpe_m1 < m_m1) ? mpe_m1 : m_m1;
    found   = (8'(cnt_lt_q) <= idx_sel) && (idx_sel < 8'(cnt_le_q));
    core    = 8'(nb_cnt_q) >= 8'(mpe);
    eps2_ext = RAD_W'(eps2_q);
    rad_new  = (r9_q > eps2_ext) ? r9_q : eps2_ext;
    nb3      = RAD_W'({dist3, 2'b00}) <= radius_q;
    n_last   = (i_q + CNT_W'(1)) == cnt_q;
    out_last = (out_i_q + CNT_W'(1)) == cnt_q;
    cur      = q_rd_q;
    push_ok  = nb_mask_q[sw_j_q[IDX_W-1:0]] && !labeled_q[sw_j_q[IDX_W-1:0]]
               && !queued_q[sw_j_q[IDX_W-1:0]] && (tail_q < CNT_W'(MAX_POINTS));
    sw_last  = (sw_j_q + CNT_W'(1)) == ((state_q == dbc_pkg::S_RCNT) ? m_q : cnt_q);
    pt_drained = !sw_iss_q && !v1_q && !v2_q && !v3_q;
    dr_drained = !sw_iss_q && !v1_q;
    for (int d = 0; d < MAX_DIMS; d++) begin
      in_pt[d*COORD_BITS +: COORD_BITS] =
        s_axis_tdata_i[d*dbc_pkg::IN_FIELD_W +: COORD_BITS];
    end
  end

  // distance lanes and merge
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
    dbc_lane #(.COORD_BITS(COORD_BITS)) u_lane (
      .clk_i (clk_i),
      .en_i  (dbc_pkg::DIMS_W'(d) < dims_eff),
      .a_i   (base_q[d*COORD_BITS +: COORD_BITS]),
      .b_i   (pt_rd_q[d*COORD_BITS +: COORD_BITS]),
      .sq_o  (lane_sq[d*SQ_W +: SQ_W])
    );
  end

  dbc_merge #(.MAX_DIMS(MAX_DIMS), .COORD_BITS(COORD_BITS)) u_merge (
    .clk_i (clk_i),
    .sq_i  (lane_sq),
    .sum_o (dist3)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dbc_pkg::S_LOAD:   if (in_fire && s_axis_tlast_i) state_d = dbc_pkg::S_START;
      dbc_pkg::S_START: begin
        if (cnt_q == CNT_W'(1)) state_d = dbc_pkg::S_LONE;
        else if (adapt_q) state_d = dbc_pkg::S_BASE;
        else state_d = dbc_pkg::S_OUTER;
      end
      dbc_pkg::S_LONE:   state_d = dbc_pkg::S_OUT_RD;
      dbc_pkg::S_BASE:   state_d = dbc_pkg::S_BASEW;
      dbc_pkg::S_BASEW:  state_d = phase_rad_q ? dbc_pkg::S_RROW : dbc_pkg::S_NBR;
      dbc_pkg::S_RROW:   if (pt_drained) state_d = dbc_pkg::S_RCAND;
      dbc_pkg::S_RCAND:  state_d = dbc_pkg::S_RCW;
      dbc_pkg::S_RCW:    state_d = dbc_pkg::S_RCNT;
      dbc_pkg::S_RCNT:   if (dr_drained) state_d = dbc_pkg::S_RCHK;
      dbc_pkg::S_RCHK:   state_d = found ? dbc_pkg::S_RWR : dbc_pkg::S_RCAND;
      dbc_pkg::S_RWR:    state_d = n_last ? dbc_pkg::S_OUTER : dbc_pkg::S_BASE;
      dbc_pkg::S_OUTER: begin
        state_d = visited_q[i_q[IDX_W-1:0]] ? dbc_pkg::S_NEXT : dbc_pkg::S_BASE;
      end
      dbc_pkg::S_NEXT:   state_d = n_last ? dbc_pkg::S_OUT_RD : dbc_pkg::S_OUTER;
      dbc_pkg::S_NBR:    if (pt_drained) state_d = dbc_pkg::S_DEC;
      dbc_pkg::S_DEC: begin
        if (core) state_d = dbc_pkg::S_PUSH;
        else if (from_outer_q) state_d = dbc_pkg::S_NEXT;
        else state_d = dbc_pkg::S_POP;
      end
      dbc_pkg::S_PUSH:   if (sw_last) state_d = dbc_pkg::S_POP;
      dbc_pkg::S_POP:    state_d = (head_q == tail_q) ? dbc_pkg::S_NEXT : dbc_pkg::S_POPW;
      dbc_pkg::S_POPW: begin
        if (labeled_q[cur] || visited_q[cur]) state_d = dbc_pkg::S_POP;
        else state_d = dbc_pkg::S_BASE;
      end
      dbc_pkg::S_OUT_RD:   state_d = dbc_pkg::S_OUT_SHOW;
      dbc_pkg::S_OUT_SHOW: begin
        if (out_fire) state_d = out_last ? dbc_pkg::S_LOAD : dbc_pkg::S_OUT_RD;
      end
      default: state_d = dbc_pkg::S_LOAD;
    endcase
  end

  // outputs and read addresses
  always_comb begin
    s_axis_tready_o = state_q == dbc_pkg::S_LOAD;
    m_axis_tvalid_o = state_q == dbc_pkg::S_OUT_SHOW;
    sweep_st = (state_q == dbc_pkg::S_RROW) || (state_q == dbc_pkg::S_NBR)
               || (state_q == dbc_pkg::S_RCNT);
    pt_sweep = (state_q == dbc_pkg::S_RROW) || (state_q == dbc_pkg::S_NBR);
    pt_addr   = pt_sweep ? sw_j_q[IDX_W-1:0] : p_q[IDX_W-1:0];
    drow_addr = (state_q == dbc_pkg::S_RCNT) ? sw_j_q[IDX_W-1:0] : c_q[IDX_W-1:0];
    lbl_out = labeled_q[out_i_q[IDX_W-1:0]] ? dbc_pkg::LBL_W'(lbl_rd_q)
                                             : dbc_pkg::LBL_NOISE;
    m_axis_tdata_o = {4'd0, ovf_q,
                      dbc_pkg::TOT_W'(cnt_q - lab_cnt_q),
                      dbc_pkg::TOT_W'(cluster_q),
                      lbl_out,
                      dbc_pkg::PIDX_W'(out_i_q[IDX_W-1:0])};
    m_axis_tlast_o = out_last;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (in_fire && (cnt_q < CNT_W'(MAX_POINTS))) begin
      pt_mem[cnt_q[IDX_W-1:0]] <= in_pt;
    end
    pt_rd_q <= pt_mem[pt_addr];
    if (state_q == dbc_pkg::S_RWR) begin
      rad_mem[i_q[IDX_W-1:0]] <= rad_new;
    end
    rad_rd_q <= rad_mem[p_q[IDX_W-1:0]];
    if ((state_q == dbc_pkg::S_RROW) && v3_q && (j3_q != i_q[IDX_W-1:0])) begin
      drow_mem[m_q[IDX_W-1:0]] <= dist3;
    end
    drow_rd_q <= drow_mem[drow_addr];
    if (state_q == dbc_pkg::S_LONE) begin
      lbl_mem[0] <= '0;
    end else if ((state_q == dbc_pkg::S_DEC) && from_outer_q && core) begin
      lbl_mem[p_q[IDX_W-1:0]] <= cluster_q;
    end else if ((state_q == dbc_pkg::S_POPW) && !labeled_q[cur]) begin
      lbl_mem[cur] <= cluster_q;
    end
    lbl_rd_q <= lbl_mem[out_i_q[IDX_W-1:0]];
    if ((state_q == dbc_pkg::S_PUSH) && push_ok) begin
      q_mem[tail_q[IDX_W-1:0]] <= sw_j_q[IDX_W-1:0];
    end
    q_rd_q <= q_mem[head_q[IDX_W-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    j1_q <= sw_j_q[IDX_W-1:0];
    j2_q <= j1_q;
    j3_q <= j2_q;
    if (state_q == dbc_pkg::S_START) begin
      eps2_q <= eps_eff * eps_eff;
    end
    if (state_q == dbc_pkg::S_BASEW) begin
      base_q   <= pt_rd_q;
      radius_q <= adapt_q ? rad_rd_q : RAD_W'({eps2_q, 2'b00});
    end
    if (state_q == dbc_pkg::S_RCW) begin
      dc_q <= drow_rd_q;
    end
    if (state_q == dbc_pkg::S_RCHK) begin
      r9_q <= RAD_W'({dc_q, 3'b000}) + RAD_W'(dc_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dbc_pkg::S_LOAD;
      eps_q        <= dbc_pkg::EPS_RST;
      minpts_q     <= dbc_pkg::MINPTS_RST;
      adapt_q      <= 1'b0;
      dims_q       <= dbc_pkg::DIMS_RST;
      cnt_q        <= '0;
      i_q          <= '0;
      p_q          <= '0;
      m_q          <= '0;
      c_q          <= '0;
      sw_j_q       <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      out_i_q      <= '0;
      lab_cnt_q    <= '0;
      cluster_q    <= '0;
      nb_cnt_q     <= '0;
      cnt_lt_q     <= '0;
      cnt_le_q     <= '0;
      ovf_q        <= 1'b0;
      phase_rad_q  <= 1'b0;
      from_outer_q <= 1'b0;
      sw_iss_q     <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      labeled_q    <= '0;
      visited_q    <= '0;
      queued_q     <= '0;
      nb_mask_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (dbc_pkg::cfg_reg_e'(cfg_idx_i))
          dbc_pkg::CFG_EPS:    eps_q    <= cfg_data_i[dbc_pkg::EPS_W-1:0];
          dbc_pkg::CFG_MINPTS: minpts_q <= cfg_data_i[dbc_pkg::MINPTS_W-1:0];
          dbc_pkg::CFG_ADAPT:  adapt_q  <= cfg_data_i[0];
          dbc_pkg::CFG_DIMS:   dims_q   <= cfg_data_i[dbc_pkg::DIMS_W-1:0];
          default: ;
        endcase
      end

      // shared walk: issue one address a cycle, tags follow the data
      v1_q <= sw_iss_q && sweep_st;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (sw_iss_q && sweep_st) begin
        sw_j_q <= sw_j_q + CNT_W'(1);
        if (sw_last) sw_iss_q <= 1'b0;
      end

      case (state_q)
        dbc_pkg::S_LOAD: begin
          if (in_fire) begin
            if (cnt_q < CNT_W'(MAX_POINTS)) cnt_q <= cnt_q + CNT_W'(1);
            else ovf_q <= 1'b1;
          end
        end
        dbc_pkg::S_START: begin
          i_q         <= '0;
          p_q         <= '0;
          phase_rad_q <= adapt_q;
        end
        dbc_pkg::S_LONE: begin
          labeled_q[0] <= 1'b1;
          lab_cnt_q    <= CNT_W'(1);
          cluster_q    <= CNT_W'(1);
          out_i_q      <= '0;
        end
        dbc_pkg::S_BASEW: begin
          m_q       <= '0;
          nb_cnt_q  <= '0;
          nb_mask_q <= '0;
          sw_j_q    <= '0;
          sw_iss_q  <= 1'b1;
        end
        dbc_pkg::S_RROW: begin
          if (v3_q && (j3_q != i_q[IDX_W-1:0])) m_q <= m_q + CNT_W'(1);
          c_q <= '0;
        end
        dbc_pkg::S_RCW: begin
          cnt_lt_q <= '0;
          cnt_le_q <= '0;
          sw_j_q   <= '0;
          sw_iss_q <= 1'b1;
        end
        dbc_pkg::S_RCNT: begin
          if (v1_q) begin
            if (drow_rd_q < dc_q) cnt_lt_q <= cnt_lt_q + CNT_W'(1);
            if (drow_rd_q <= dc_q) cnt_le_q <= cnt_le_q + CNT_W'(1);
          end
        end
        dbc_pkg::S_RCHK: begin
          if (!found) c_q <= c_q + CNT_W'(1);
        end
        dbc_pkg::S_RWR: begin
          if (n_last) begin
            i_q         <= '0;
            phase_rad_q <= 1'b0;
          end else begin
            i_q <= i_q + CNT_W'(1);
            p_q <= i_q + CNT_W'(1);
          end
        end
        dbc_pkg::S_OUTER: begin
          if (!visited_q[i_q[IDX_W-1:0]]) begin
            visited_q[i_q[IDX_W-1:0]] <= 1'b1;
            p_q          <= i_q;
            from_outer_q <= 1'b1;
          end
        end
        dbc_pkg::S_NEXT: begin
          if (n_last) out_i_q <= '0;
          else i_q <= i_q + CNT_W'(1);
        end
        dbc_pkg::S_NBR: begin
          if (v3_q) begin
            nb_mask_q[j3_q] <= nb3;
            if (nb3) nb_cnt_q <= nb_cnt_q + CNT_W'(1);
          end
        end
        dbc_pkg::S_DEC: begin
          sw_j_q <= '0;
          if (from_outer_q && core) begin
            labeled_q[p_q[IDX_W-1:0]] <= 1'b1;
            lab_cnt_q <= lab_cnt_q + CNT_W'(1);
            queued_q  <= '0;
            head_q    <= '0;
            tail_q    <= '0;
          end
        end
        dbc_pkg::S_PUSH: begin
          sw_j_q <= sw_j_q + CNT_W'(1);
          if (push_ok) begin
            queued_q[sw_j_q[IDX_W-1:0]] <= 1'b1;
            tail_q <= tail_q + CNT_W'(1);
          end
        end
        dbc_pkg::S_POP: begin
          if (head_q == tail_q) cluster_q <= cluster_q + CNT_W'(1);
          else head_q <= head_q + CNT_W'(1);
        end
        dbc_pkg::S_POPW: begin
          if (!labeled_q[cur]) begin
            labeled_q[cur] <= 1'b1;
            lab_cnt_q <= lab_cnt_q + CNT_W'(1);
            if (!visited_q[cur]) begin
              visited_q[cur] <= 1'b1;
              p_q          <= CNT_W'(cur);
              from_outer_q <= 1'b0;
            end
          end
        end
        dbc_pkg::S_OUT_SHOW: begin
          if (out_fire) begin
            if (out_last) begin
              cnt_q     <= '0;
              ovf_q     <= 1'b0;
              labeled_q <= '0;
              visited_q <= '0;
              queued_q  <= '0;
              cluster_q <= '0;
              lab_cnt_q <= '0;
            end else begin
              out_i_q <= out_i_q + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/dbc_checker.sv]
`include "assert_macros.svh"

module dbc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [dbc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tlast_o
);

  `DBC_ASSERT_NEVER(a_one_side, clk_i, rst_ni, s_axis_tready_o && m_axis_tvalid_o)
  `DBC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
  `DBC_ASSERT(a_last_ends, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> !m_axis_tvalid_o)
  `DBC_ASSERT(a_idx_step, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> ##1 (m_axis_tdata_o[5:0] == $past(m_axis_tdata_o[5:0], 2) + 6'd1))

endmodule

bind dbscan_cluster_labeler dbc_checker u_dbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

[tb/dbscan_cluster_labeler_checker.sv]
`timescale 1ns / 100ps

module dbscan_cluster_labeler_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           pt_valid_i,
  input  logic                           pt_ready_i,
  input  logic [dbc_pkg::IN_DATA_W-1:0]  pt_data_i,
  input  logic                           pt_last_i,
  input  logic                           lbl_valid_i,
  input  logic                           lbl_ready_i,
  input  logic [dbc_pkg::OUT_DATA_W-1:0] lbl_data_i,
  input  logic                           lbl_last_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             label_count_o
);

  typedef struct packed {
    logic [dbc_pkg::PIDX_W-1:0] pidx;
    logic [dbc_pkg::LBL_W-1:0]  lbl;
    logic                       last;
    logic [dbc_pkg::TOT_W-1:0]  clusters;
    logic [dbc_pkg::TOT_W-1:0]  noise;
    logic                       ovf;
  } label_t;

  localparam int NPTS = dbc_pkg::DEF_MAX_POINTS;

  logic signed [16:0]           pts [NPTS][4];
  logic [39:0]                  rad_sq [NPTS];
  int                           lbl [NPTS];
  bit                           seen [NPTS];
  int                           n_pts;
  bit                           ovf;
  logic [dbc_pkg::EPS_W-1:0]    eps;
  logic [dbc_pkg::MINPTS_W-1:0] minpts;
  logic                         adapt;
  logic [dbc_pkg::DIMS_W-1:0]   dims;
  label_t                       label_q [$];

  function automatic int dims_used();
    if (dims == 0) return 1;
    if (dims > 4) return 4;
    return dims;
  endfunction

  function automatic logic [39:0] dist_sq(int a, int b);
    logic [39:0] s;
    logic signed [17:0] df;
    s = 0;
    for (int d = 0; d < dims_used(); d++) begin
      df = pts[a][d] - pts[b][d];
      s += 40'(df) * 40'(df);
    end
    return s;
  endfunction

  function automatic bit near(int p, int j);
    return ({2'b0, dist_sq(p, j)} << 2) <= {2'b0, rad_sq[p]};
  endfunction

  function automatic int kmin();
    return minpts < 2 ? 2 : minpts;
  endfunction

  function automatic bit is_core(int p);
    int c;
    c = 0;
    for (int j = 0; j < n_pts; j++) if (near(p, j)) c++;
    return c >= kmin();
  endfunction

  task automatic cluster_set();
    logic [39:0] e2;
    logic [39:0] ds [$];
    int idx, head, cl, cur, noise;
    bit queued [NPTS];
    int seeds [$];
    label_t r;
    cl = 0;
    for (int i = 0; i < NPTS; i++) begin
      lbl[i] = -1;
      seen[i] = 0;
    end
    if (n_pts == 1) begin
      lbl[0] = 0;
      cl = 1;
    end else begin
      e2 = (eps == 0) ? 40'd1 : 40'(eps) * 40'(eps);
      for (int i = 0; i < n_pts; i++) begin
        if (!adapt) begin
          rad_sq[i] = e2 << 2;
        end else begin
          ds.delete();
          for (int j = 0; j < n_pts; j++) if (j != i) ds.push_back(dist_sq(i, j));
          ds.sort();
          idx = (kmin() - 1 < ds.size() - 1) ? kmin() - 1 : ds.size() - 1;
          rad_sq[i] = (9 * ds[idx] > e2) ? 9 * ds[idx] : e2;
        end
      end
      for (int i = 0; i < n_pts; i++) begin
        if (seen[i]) continue;
        seen[i] = 1;
        if (!is_core(i)) continue;
        lbl[i] = cl;
        foreach (queued[q]) queued[q] = 0;
        seeds.delete();
        for (int j = 0; j < n_pts; j++)
          if (j != i && lbl[j] < 0 && near(i, j)) begin
            queued[j] = 1;
            seeds.push_back(j);
          end
        head = 0;
        while (head < seeds.size()) begin
          cur = seeds[head];
          head++;
          if (lbl[cur] >= 0) continue;
          lbl[cur] = cl;
          if (seen[cur]) continue;
          seen[cur] = 1;
          if (!is_core(cur)) continue;
          for (int j = 0; j < n_pts; j++)
            if (lbl[j] < 0 && !queued[j] && near(cur, j) && seeds.size() < NPTS) begin
              queued[j] = 1;
              seeds.push_back(j);
            end
        end
        cl++;
      end
    end
    noise = 0;
    for (int i = 0; i < n_pts; i++) if (lbl[i] < 0) noise++;
    for (int i = 0; i < n_pts; i++) begin
      r.pidx = dbc_pkg::PIDX_W'(i);
      r.lbl = dbc_pkg::LBL_W'(lbl[i]);
      r.last = (i + 1 == n_pts);
      r.clusters = dbc_pkg::TOT_W'(cl);
      r.noise = dbc_pkg::TOT_W'(noise);
      r.ovf = ovf;
      label_q.push_back(r);
    end
    n_pts = 0;
    ovf = 0;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    label_t g, w;
    if (!rst_ni) begin
      eps = dbc_pkg::EPS_RST;
      minpts = dbc_pkg::MINPTS_RST;
      adapt = 0;
      dims = dbc_pkg::DIMS_RST;
      n_pts = 0;
      ovf = 0;
      fail_count_o = 0;
      label_count_o = 0;
      label_q.delete();
    end else begin
      if (lbl_valid_i && lbl_ready_i) begin
        label_count_o++;
        g.pidx = lbl_data_i[5:0];
        g.lbl = lbl_data_i[12:6];
        g.clusters = lbl_data_i[19:13];
        g.noise = lbl_data_i[26:20];
        g.ovf = lbl_data_i[27];
        g.last = lbl_last_i;
        if (label_q.size() == 0) begin
          report("unexpected label for point", g.pidx, -1);
        end else begin
          w = label_q.pop_front();
          if (g.pidx != w.pidx) report("point_index", g.pidx, w.pidx);
          if (g.lbl != w.lbl) report("cluster_label", $signed(g.lbl), $signed(w.lbl));
          if (g.last != w.last) report("final_label", g.last, w.last);
          if (g.clusters != w.clusters) report("cluster_total", g.clusters, w.clusters);
          if (g.noise != w.noise) report("noise_total", g.noise, w.noise);
          if (g.ovf != w.ovf) report("overflowed", g.ovf, w.ovf);
        end
      end
      if (cfg_we_i) begin
        case (dbc_pkg::cfg_reg_e'(cfg_idx_i))
          dbc_pkg::CFG_EPS:    eps = cfg_data_i;
          dbc_pkg::CFG_MINPTS: minpts = cfg_data_i[dbc_pkg::MINPTS_W-1:0];
          dbc_pkg::CFG_ADAPT:  adapt = cfg_data_i[0];
          dbc_pkg::CFG_DIMS:   dims = cfg_data_i[dbc_pkg::DIMS_W-1:0];
          default: ;
        endcase
      end
      if (pt_valid_i && pt_ready_i) begin
        if (n_pts < NPTS) begin
          for (int d = 0; d < 4; d++) pts[n_pts][d] = $signed(pt_data_i[16*d +: 16]);
          n_pts++;
        end else begin
          ovf = 1;
        end
        if (pt_last_i) cluster_set();
      end
    end
    pending_o = label_q.size();
  end

endmodule

[tb/dbscan_cluster_labeler_tb.sv]
`timescale 1ns / 100ps

module dbscan_cluster_labeler_tb;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [dbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [dbc_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [dbc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                           s_axis_tlast_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [dbc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                           m_axis_tlast_o;
  int                             fail_count;
  int                             pending;
  int                             label_count;
  int                             point_count;
  int                             set_count;
  bit                             calm;

  dbscan_cluster_labeler u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tlast_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o
  );

  dbscan_cluster_labeler_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pt_valid_i(s_axis_tvalid_i), .pt_ready_i(s_axis_tready_o),
    .pt_data_i(s_axis_tdata_i), .pt_last_i(s_axis_tlast_i),
    .lbl_valid_i(m_axis_tvalid_o), .lbl_ready_i(m_axis_tready_i),
    .lbl_data_i(m_axis_tdata_o), .lbl_last_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending), .label_count_o(label_count)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #80ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk_i) m_axis_tready_i <= calm || ($urandom_range(99) >= 9);

  task automatic write_reg(dbc_pkg::cfg_reg_e idx, logic [dbc_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  // hold valid after the transfer; the next point or drain() updates it
  task automatic send_point(logic [dbc_pkg::IN_DATA_W-1:0] data, bit last);
    while (!calm && $urandom_range(99) < 9) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= data;
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    point_count++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [15:0] coord(int center, int spread);
    return 16'(center + $signed($urandom_range(2 * spread)) - spread);
  endfunction

  // clustered blobs with some scattered noise
  task automatic send_set(int n, int spread);
    int cx [4];
    logic [dbc_pkg::IN_DATA_W-1:0] p;
    for (int i = 0; i < n; i++) begin
      if (i % 5 == 0) foreach (cx[d]) cx[d] = $signed(16'($urandom));
      if ($urandom_range(9) == 0) p = {$urandom, $urandom};
      else for (int d = 0; d < 4; d++) p[16*d +: 16] = coord(cx[d], spread);
      send_point(p, i == n - 1);
    end
    set_count++;
    drain();
  endtask

  initial begin
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = dbc_pkg::CFG_EPS;
    cfg_data_i = 0;
    s_axis_tvalid_i = 0;
    s_axis_tdata_i = 0;
    s_axis_tlast_i = 0;
    m_axis_tready_i = 0;
    calm = 0;
    point_count = 0;
    set_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // lone point
    send_point({16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF}, 1);
    drain();
    // extremes, default registers
    send_point({4{16'h8000}}, 0);
    send_point({4{16'h7FFF}}, 0);
    send_point({4{16'h0000}}, 0);
    send_point({4{16'h0001}}, 0);
    send_point({4{16'hFFFF}}, 0);
    send_point({4{16'h0100}}, 1);
    drain();
    write_reg(dbc_pkg::CFG_EPS, 16'd1);
    write_reg(dbc_pkg::CFG_MINPTS, 16'd2);
    write_reg(dbc_pkg::CFG_DIMS, 16'd4);
    send_point({4{16'h0000}}, 0);
    send_point({4{16'h0000}}, 0);
    send_point({4{16'h0001}}, 0);
    send_point({4{16'h5555}}, 1);
    drain();
    write_reg(dbc_pkg::CFG_EPS, 16'hFFFF);
    write_reg(dbc_pkg::CFG_MINPTS, 16'd64);
    write_reg(dbc_pkg::CFG_ADAPT, 16'd1);
    write_reg(dbc_pkg::CFG_DIMS, 16'd1);
    send_point({4{16'hAAAA}}, 0);
    send_point({4{16'h5555}}, 0);
    send_point({4{16'h8000}}, 1);
    drain();

    // overflow: 66 points, the last two dropped
    write_reg(dbc_pkg::CFG_ADAPT, 16'd0);
    write_reg(dbc_pkg::CFG_MINPTS, 16'd3);
    write_reg(dbc_pkg::CFG_EPS, 16'd2000);
    calm = 1;
    for (int i = 0; i < 66; i++) send_point({$urandom, $urandom} & 64'h03FF_03FF_03FF_03FF,
                                            i == 65);
    calm = 0;
    set_count++;
    drain();

    for (int r = 0; r < 14; r++) begin
      write_reg(dbc_pkg::CFG_EPS, 16'($urandom_range(1, 4000)));
      write_reg(dbc_pkg::CFG_MINPTS, 16'($urandom_range(2, 6)));
      write_reg(dbc_pkg::CFG_ADAPT, 16'($urandom_range(1)));
      write_reg(dbc_pkg::CFG_DIMS, 16'($urandom_range(1, 4)));
      calm = (r == 5);
      send_set($urandom_range(2, 12), (r % 3 == 0) ? 400 : 60);
    end
    calm = 0;
    drain();
    repeat (100) @(posedge clk_i);

    $display("sent %0d points in %0d sets; checked %0d labels", point_count,
             set_count + 4, label_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
